// ----- src/dfl_box_pkg.sv -----
package dfl_box_pkg;

  localparam int unsigned NumBins    = 16;
  localparam int unsigned NumClasses = 80;
  localparam int unsigned BinW       = $clog2(NumBins);
  localparam int unsigned ExpSteps   = 12;
  localparam int unsigned DvdW       = 40;
  localparam int unsigned DvsW       = 21;
  localparam int unsigned QuoW       = 17;

  localparam logic [15:0] BoxMax = 16'sd32767;
  localparam logic [15:0] BoxMin = 16'h C000;

  typedef enum logic [0:0] {
    REQ_BIN   = 1'b0,
    REQ_CLASS = 1'b1
  } req_type_e;

  typedef enum logic [0:0] {
    KIND_BOX   = 1'b0,
    KIND_SCORE = 1'b1
  } result_kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SIG_MUL,
    ST_SIG_W,
    ST_MAX,
    ST_EXP,
    ST_ACC,
    ST_DIV,
    ST_BOX,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic               req_type;
    logic [1:0]         side;
    logic [3:0]         bin;
    logic [6:0]         class_index;
    logic signed [15:0] logit_value;
    logic [7:0]         anchor_x_half;
    logic [7:0]         anchor_y_half;
    logic [1:0]         stride_code;
    logic               last_row;
  } in_req_t;

  typedef struct packed {
    logic               result_kind;
    logic signed [15:0] box_x1;
    logic signed [15:0] box_y1;
    logic signed [15:0] box_x2;
    logic signed [15:0] box_y2;
    logic [15:0]        class_score;
    logic [6:0]         score_class;
    logic               end_of_set;
  } out_res_t;

  // e^-i in Q16
  function automatic logic [16:0] exp_int(input logic [3:0] i);
    logic [16:0] v;
    begin
      case (i)
        4'd0:    v = 17'd65536;
        4'd1:    v = 17'd24109;
        4'd2:    v = 17'd8869;
        4'd3:    v = 17'd3263;
        4'd4:    v = 17'd1200;
        4'd5:    v = 17'd442;
        4'd6:    v = 17'd162;
        4'd7:    v = 17'd60;
        4'd8:    v = 17'd22;
        4'd9:    v = 17'd8;
        4'd10:   v = 17'd3;
        4'd11:   v = 17'd1;
        default: v = 17'd0;
      endcase
      return v;
    end
  endfunction

  // e^(-k/16) in Q16
  function automatic logic [16:0] exp_frac(input logic [3:0] k);
    logic [16:0] v;
    begin
      case (k)
        4'd0:    v = 17'd65536;
        4'd1:    v = 17'd61565;
        4'd2:    v = 17'd57835;
        4'd3:    v = 17'd54331;
        4'd4:    v = 17'd51039;
        4'd5:    v = 17'd47947;
        4'd6:    v = 17'd45042;
        4'd7:    v = 17'd42313;
        4'd8:    v = 17'd39750;
        4'd9:    v = 17'd37341;
        4'd10:   v = 17'd35079;
        4'd11:   v = 17'd32953;
        4'd12:   v = 17'd30957;
        4'd13:   v = 17'd29081;
        4'd14:   v = 17'd27319;
        default: v = 17'd25664;
      endcase
      return v;
    end
  endfunction

endpackage

// ----- src/dfl_box_decode_sigmoid_core.sv -----
// Box decoder for distribution bin logits, with sigmoid class scores.
// Input channel: in_valid_i / in_stall_o carry one request (in_data_i).
// Output channel: out_valid_o / out_stall_i carry one result (out_data_o).
// A bin request other than the last bin of a side is stored on acceptance and
// gives no result. A class request runs a table exponential (SIG_MUL, SIG_W)
// and the shared restoring divider, then goes to the output register.
// The last bin of a side runs a max pass, an exponential pass (EXP and ACC
// for each bin) and the divider; side three then adds box arithmetic and
// the output register. A class request whose class number is out of range
// is dropped. in_stall_o is high from the request's acceptance until its
// result sits in the output register, or for sides without a result until
// the divider ends, so no request is taken before the last one is through.
// When the receiver stalls, the result holds there and a
// further finished result waits in the sequencer until the register frees.
// Reset clears the sequencer and output valid; the logit store and side
// distances hold no reset value and must be written before use.
module dfl_box_decode_sigmoid_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  dfl_box_pkg::in_req_t in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output dfl_box_pkg::out_res_t out_data_o
);

  dfl_box_pkg::state_e state_q, state_d;

  logic signed [15:0] store_q [dfl_box_pkg::NumBins];
  logic [15:0]        dist_q  [4];

  dfl_box_pkg::in_req_t  req_q;
  dfl_box_pkg::out_res_t res_q, res_d;
  dfl_box_pkg::out_res_t out_q;
  logic                  out_valid_q;

  logic [5:0]         cnt_q, cnt_d;
  logic signed [15:0] mx_q, mx_d;
  logic [33:0]        prod_q;
  logic               big_q;
  logic [20:0]        sum_q, sum_d;
  logic [23:0]        wsum_q, wsum_d;
  logic [dfl_box_pkg::DvdW-1:0] dvd_q, dvd_d;
  logic [dfl_box_pkg::DvsW-1:0] dvs_q, dvs_d;
  logic [dfl_box_pkg::DvsW-1:0] rem_q, rem_d;
  logic [dfl_box_pkg::QuoW-1:0] quo_q, quo_d;

  logic accept, out_free;
  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != dfl_box_pkg::ST_IDLE);

  // shared exponential front end
  logic signed [15:0] cur_logit;
  logic [16:0]        d_exp;
  logic [17:0]        d_rnd;
  logic [13:0]        q_exp;
  logic [16:0]        w_cur;
  logic [15:0]        quo_sat;
  logic [21:0]        rem_sh;
  logic               qbit;

  assign cur_logit = store_q[cnt_q[dfl_box_pkg::BinW-1:0]];

  always_comb begin
    if (state_q == dfl_box_pkg::ST_SIG_MUL) begin
      d_exp = req_q.logit_value[15] ? 17'(-{req_q.logit_value[15], req_q.logit_value})
                                    : 17'({1'b0, req_q.logit_value});
    end else begin
      d_exp = 17'({mx_q[15], mx_q} - {cur_logit[15], cur_logit});
    end
    d_rnd = {1'b0, d_exp} + 18'd8;
    q_exp = d_rnd[17:4];
    w_cur = big_q ? 17'd0 : 17'((prod_q + 34'd32768) >> 16);
  end

  // restoring divider step
  always_comb begin
    rem_sh = {rem_q, dvd_q[dfl_box_pkg::DvdW-1]};
    qbit   = (rem_sh >= {1'b0, dvs_q});
    quo_d  = {quo_q[dfl_box_pkg::QuoW-2:0], qbit};
    quo_sat = quo_d[16] ? 16'hFFFF : quo_d[15:0];
  end

  // box edges
  function automatic logic [15:0] edge_calc(input logic [7:0] half, input logic [15:0] dist_in,
                                            input logic plus, input logic [1:0] scode);
    logic signed [21:0] n;
    logic signed [27:0] s;
    logic signed [19:0] v;
    begin
      n = plus ? (22'sd0 + $signed({3'b0, half, 11'b0}) + $signed({6'b0, dist_in}))
               : (22'sd0 + $signed({3'b0, half, 11'b0}) - $signed({6'b0, dist_in}));
      case (scode)
        2'd0:    s = 28'(n) <<< 3;
        2'd1:    s = 28'(n) <<< 4;
        default: s = 28'(n) <<< 5;
      endcase
      s = s + 28'sd128;
      v = 20'(s >>> 8);
      if (v > 20'sd32767)       return dfl_box_pkg::BoxMax;
      else if (v < -20'sd16384) return dfl_box_pkg::BoxMin;
      else                      return v[15:0];
    end
  endfunction

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      dfl_box_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_data_i.req_type == dfl_box_pkg::REQ_CLASS) begin
            if (32'(in_data_i.class_index) < dfl_box_pkg::NumClasses)
              state_d = dfl_box_pkg::ST_SIG_MUL;
          end else if (32'(in_data_i.bin) == dfl_box_pkg::NumBins - 1) begin
            state_d = dfl_box_pkg::ST_MAX;
          end
        end
      end
      dfl_box_pkg::ST_SIG_MUL: state_d = dfl_box_pkg::ST_SIG_W;
      dfl_box_pkg::ST_SIG_W:   state_d = dfl_box_pkg::ST_DIV;
      dfl_box_pkg::ST_MAX: begin
        if (32'(cnt_q) == dfl_box_pkg::NumBins - 1) state_d = dfl_box_pkg::ST_EXP;
      end
      dfl_box_pkg::ST_EXP: state_d = dfl_box_pkg::ST_ACC;
      dfl_box_pkg::ST_ACC: begin
        state_d = (32'(cnt_q) == dfl_box_pkg::NumBins - 1) ? dfl_box_pkg::ST_DIV
                                                           : dfl_box_pkg::ST_EXP;
      end
      dfl_box_pkg::ST_DIV: begin
        if (32'(cnt_q) == dfl_box_pkg::DvdW - 1) begin
          if (req_q.req_type == dfl_box_pkg::REQ_CLASS) state_d = dfl_box_pkg::ST_EMIT;
          else if (req_q.side == 2'd3)                  state_d = dfl_box_pkg::ST_BOX;
          else                                          state_d = dfl_box_pkg::ST_IDLE;
        end
      end
      dfl_box_pkg::ST_BOX:  state_d = dfl_box_pkg::ST_EMIT;
      dfl_box_pkg::ST_EMIT: if (out_free) state_d = dfl_box_pkg::ST_IDLE;
      default:              state_d = dfl_box_pkg::ST_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    cnt_d  = cnt_q;
    mx_d   = mx_q;
    sum_d  = sum_q;
    wsum_d = wsum_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    res_d  = res_q;
    case (state_q)
      dfl_box_pkg::ST_IDLE: cnt_d = '0;
      dfl_box_pkg::ST_SIG_W: begin
        dvs_d = 21'd65536 + 21'(w_cur);
        if (!req_q.logit_value[15]) dvd_d = 40'h1_0000_0000 + 40'(dvs_d >> 1);
        else                        dvd_d = 40'({w_cur, 16'b0}) + 40'(dvs_d >> 1);
        rem_d = '0;
        cnt_d = '0;
      end
      dfl_box_pkg::ST_MAX: begin
        if (cnt_q == '0 || cur_logit > mx_q) mx_d = cur_logit;
        cnt_d  = (32'(cnt_q) == dfl_box_pkg::NumBins - 1) ? 6'd0 : cnt_q + 6'd1;
        sum_d  = '0;
        wsum_d = '0;
      end
      dfl_box_pkg::ST_ACC: begin
        sum_d  = sum_q + 21'(w_cur);
        wsum_d = wsum_q + 24'(w_cur) * 24'(cnt_q[dfl_box_pkg::BinW-1:0]);
        cnt_d  = cnt_q + 6'd1;
        if (32'(cnt_q) == dfl_box_pkg::NumBins - 1) begin
          dvs_d = sum_d;
          dvd_d = 40'({wsum_d, 12'b0}) + 40'(sum_d >> 1);
          rem_d = '0;
          cnt_d = '0;
        end
      end
      dfl_box_pkg::ST_DIV: begin
        rem_d = qbit ? 21'(rem_sh - {1'b0, dvs_q}) : rem_sh[20:0];
        dvd_d = {dvd_q[dfl_box_pkg::DvdW-2:0], 1'b0};
        cnt_d = cnt_q + 6'd1;
        if (32'(cnt_q) == dfl_box_pkg::DvdW - 1) begin
          res_d             = '0;
          res_d.end_of_set  = req_q.last_row;
          res_d.result_kind = dfl_box_pkg::KIND_SCORE;
          res_d.class_score = quo_sat;
          res_d.score_class = req_q.class_index;
        end
      end
      dfl_box_pkg::ST_BOX: begin
        res_d             = '0;
        res_d.result_kind = dfl_box_pkg::KIND_BOX;
        res_d.end_of_set  = req_q.last_row;
        res_d.box_x1 = edge_calc(req_q.anchor_x_half, dist_q[0], 1'b0, req_q.stride_code);
        res_d.box_y1 = edge_calc(req_q.anchor_y_half, dist_q[1], 1'b0, req_q.stride_code);
        res_d.box_x2 = edge_calc(req_q.anchor_x_half, dist_q[2], 1'b1, req_q.stride_code);
        res_d.box_y2 = edge_calc(req_q.anchor_y_half, dist_q[3], 1'b1, req_q.stride_code);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dfl_box_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (state_q == dfl_box_pkg::ST_EMIT && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i)                         out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_data_i;
      if (in_data_i.req_type == dfl_box_pkg::REQ_BIN)
        store_q[in_data_i.bin] <= in_data_i.logit_value;
    end
    prod_q <= 34'(dfl_box_pkg::exp_int(q_exp[7:4]) * dfl_box_pkg::exp_frac(q_exp[3:0]));
    big_q  <= (q_exp[13:4] >= 10'(dfl_box_pkg::ExpSteps));
    mx_q   <= mx_d;
    sum_q  <= sum_d;
    wsum_q <= wsum_d;
    dvd_q  <= dvd_d;
    dvs_q  <= dvs_d;
    rem_q  <= rem_d;
    quo_q  <= (state_q == dfl_box_pkg::ST_DIV) ? quo_d : '0;
    res_q  <= res_d;
    if (state_q == dfl_box_pkg::ST_DIV && 32'(cnt_q) == dfl_box_pkg::DvdW - 1 &&
        req_q.req_type == dfl_box_pkg::REQ_BIN)
      dist_q[req_q.side] <= quo_sat;
    if (state_q == dfl_box_pkg::ST_EMIT && out_free) out_q <= res_q;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- src/dfl_box_checker.sv -----
module dfl_box_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input dfl_box_pkg::in_req_t  in_data_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input dfl_box_pkg::out_res_t out_data_o
);

  // a result waiting on the receiver holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // a valid class request keeps the input busy while scored
  a_class_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.req_type == dfl_box_pkg::REQ_CLASS &&
    in_data_i.class_index < 7'd80 |=> in_stall_o)
    else $error("class request did not occupy the block");

  // a plain bin request is stored without stalling the input
  a_bin_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.req_type == dfl_box_pkg::REQ_BIN &&
    in_data_i.bin != 4'd15 |=> !in_stall_o)
    else $error("bin store stalled input");

  // a score result has zero box_x1 and box_y2 fields
  a_score_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.result_kind == dfl_box_pkg::KIND_SCORE |->
    out_data_o.box_x1 == 16'd0 && out_data_o.box_y2 == 16'd0)
    else $error("score result has box fields");

endmodule

bind dfl_box_decode_sigmoid_core dfl_box_checker u_dfl_box_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned WatchLimit = 6000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned ItemGoal   = 400;

  localparam logic [16:0] ExpWhole [12] = '{
    17'd65536, 17'd24109, 17'd8869, 17'd3263, 17'd1200, 17'd442,
    17'd162, 17'd60, 17'd22, 17'd8, 17'd3, 17'd1
  };
  localparam logic [16:0] ExpPart [16] = '{
    17'd65536, 17'd61565, 17'd57835, 17'd54331, 17'd51039, 17'd47947,
    17'd45042, 17'd42313, 17'd39750, 17'd37341, 17'd35079, 17'd32953,
    17'd30957, 17'd29081, 17'd27319, 17'd25664
  };

  typedef struct {
    dfl_box_pkg::in_req_t  req;
    bit                    typed;
    dfl_box_pkg::out_res_t res;
  } stim_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  dfl_box_pkg::in_req_t  in_data_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  dfl_box_pkg::out_res_t out_data_o;

  dfl_box_decode_sigmoid_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // predictor state
  int signed             bin_logits [dfl_box_pkg::NumBins];
  logic [15:0]           side_dist  [4];
  dfl_box_pkg::out_res_t pending_results [$];

  int unsigned errors = 0;
  int unsigned items_sent = 0;
  int unsigned tx_idle_pct = 6;
  int unsigned rx_idle_pct = 72;
  bit          hold_req = 1'b0;
  int unsigned hold_cnt = 0;
  int unsigned quiet_cycles = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic longint unsigned exp_weight(longint unsigned d);
    longint unsigned q, i, k;
    q = (d + 8) >> 4;
    i = q >> 4;
    k = q & 15;
    if (i >= 12) return 0;
    return (ExpWhole[i] * ExpPart[k] + 32768) >> 16;
  endfunction

  function automatic logic [15:0] sigmoid_score(int signed x);
    longint unsigned e, den, num, s;
    e = exp_weight((x < 0) ? -x : x);
    den = 65536 + e;
    num = (x >= 0) ? 64'd4294967296 : 65536 * e;
    s = (num + den / 2) / den;
    return (s > 65535) ? 16'hFFFF : s[15:0];
  endfunction

  function automatic logic [15:0] expected_distance();
    int signed mx;
    longint unsigned w, sum, wsum, r;
    mx = bin_logits[0];
    sum = 0;
    wsum = 0;
    for (int k = 1; k < dfl_box_pkg::NumBins; k++) if (bin_logits[k] > mx) mx = bin_logits[k];
    for (int k = 0; k < dfl_box_pkg::NumBins; k++) begin
      w = exp_weight(mx - bin_logits[k]);
      sum += w;
      wsum += w * k;
    end
    if (sum == 0) return 16'd0;
    r = (wsum * 4096 + sum / 2) / sum;
    return (r > 65535) ? 16'hFFFF : r[15:0];
  endfunction

  function automatic logic [15:0] edge_pos(int unsigned c, logic [15:0] dist_in, bit plus,
                                           int unsigned stride);
    longint signed n, v;
    n = longint'(c) * 2048;
    n = plus ? n + dist_in : n - dist_in;
    n = n * stride + 128;
    v = (n >= 0) ? n / 256 : -((-n + 255) / 256);
    if (v < -16384) v = -16384;
    if (v > 32767) v = 32767;
    return v[15:0];
  endfunction

  function automatic bit predict_result(dfl_box_pkg::in_req_t r,
                                        output dfl_box_pkg::out_res_t o);
    int unsigned stride;
    o = '0;
    stride = (r.stride_code == 2'd0) ? 8 : (r.stride_code == 2'd1) ? 16 : 32;
    if (r.req_type == dfl_box_pkg::REQ_CLASS) begin
      if (r.class_index >= dfl_box_pkg::NumClasses) return 1'b0;
      o.result_kind = dfl_box_pkg::KIND_SCORE;
      o.class_score = sigmoid_score(r.logit_value);
      o.score_class = r.class_index;
      o.end_of_set  = r.last_row;
      return 1'b1;
    end
    bin_logits[r.bin] = r.logit_value;
    if (r.bin != dfl_box_pkg::NumBins - 1) return 1'b0;
    side_dist[r.side] = expected_distance();
    if (r.side != 2'd3) return 1'b0;
    o.result_kind = dfl_box_pkg::KIND_BOX;
    o.box_x1 = edge_pos(r.anchor_x_half, side_dist[0], 1'b0, stride);
    o.box_y1 = edge_pos(r.anchor_y_half, side_dist[1], 1'b0, stride);
    o.box_x2 = edge_pos(r.anchor_x_half, side_dist[2], 1'b1, stride);
    o.box_y2 = edge_pos(r.anchor_y_half, side_dist[3], 1'b1, stride);
    o.end_of_set = r.last_row;
    return 1'b1;
  endfunction

  // offer one request, wait until it is taken, then record what it should yield
  task automatic push_request(dfl_box_pkg::in_req_t r, bit typed = 1'b0,
                              dfl_box_pkg::out_res_t typed_res = '0);
    dfl_box_pkg::out_res_t o;
    bit got;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    do @(posedge clk_i); while (in_stall_o);
    got = predict_result(r, o);
    if (typed) o = typed_res;
    if (got) pending_results.insert(pending_results.size(), o);
    items_sent++;
  endtask

  function automatic dfl_box_pkg::in_req_t class_request(int unsigned cls, logic [15:0] logit);
    dfl_box_pkg::in_req_t r;
    r = '0;
    r.req_type    = dfl_box_pkg::REQ_CLASS;
    r.class_index = 7'(cls);
    r.logit_value = logit;
    r.side        = 2'($urandom_range(3));
    r.bin         = 4'($urandom_range(15));
    r.last_row    = 1'($urandom_range(1));
    return r;
  endfunction

  function automatic logic [15:0] random_logit(int unsigned shape, int signed center);
    case (shape)
      0:       return 16'($urandom_range(65535));
      1:       return 16'(center + $signed($urandom_range(1023)) - 512);
      default: return 16'(center + $signed($urandom_range(4095)) - 2048);
    endcase
  endfunction

  // one anchor: four sides of bin logits with class noise mixed in
  task automatic push_anchor(bit full);
    dfl_box_pkg::in_req_t r;
    int unsigned order [$];
    int unsigned shape, tmp, j;
    int signed center;
    logic [7:0] ax, ay;
    logic [1:0] sc;
    ax = 8'($urandom_range(1, 255));
    ay = 8'($urandom_range(1, 255));
    if ($urandom_range(9) == 0) begin
      ax = 8'd255;
      ay = 8'd1;
    end else if ($urandom_range(9) == 0) begin
      ax = 8'd1;
      ay = 8'd255;
    end
    sc = 2'($urandom_range(3));
    for (int s = 0; s < 4; s++) begin
      order.delete();
      for (int b = 0; b < dfl_box_pkg::NumBins - 1; b++)
        if (full || $urandom_range(2) != 0) order.insert(order.size(), b);
      for (int n = order.size() - 1; n > 0; n--) begin
        j = $urandom_range(n);
        tmp = order[n];
        order[n] = order[j];
        order[j] = tmp;
      end
      order.insert(order.size(), dfl_box_pkg::NumBins - 1);
      shape = $urandom_range(3);
      center = $signed($urandom_range(20000)) - 10000;
      foreach (order[n]) begin
        if ($urandom_range(9) == 0)
          push_request(class_request($urandom_range(127), 16'($urandom_range(65535))));
        r = '0;
        r.req_type      = dfl_box_pkg::REQ_BIN;
        r.side          = 2'(s);
        r.bin           = 4'(order[n]);
        r.class_index   = 7'($urandom_range(127));
        r.anchor_x_half = ax;
        r.anchor_y_half = ay;
        r.stride_code   = sc;
        r.last_row      = 1'($urandom_range(1));
        r.logit_value   = random_logit(shape, center);
        // a peaked distribution drives the distance toward one bin
        if (shape == 3 && order[n] == (s == 0 ? 0 : 15)) r.logit_value = 16'(center + 4000);
        push_request(r);
      end
    end
  endtask

  initial begin
    stim_row_t rows [$];
    stim_row_t row;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    row.typed = 1'b1;
    row.res = '0;
    row.res.result_kind = dfl_box_pkg::KIND_SCORE;
    row.req = class_request(0, 16'sd0);
    row.res.class_score = 16'd32768;
    row.res.end_of_set = row.req.last_row;
    rows.insert(rows.size(), row);
    row.req = class_request(79, 16'sh7FFF);
    row.res.score_class = 7'd79;
    row.res.class_score = 16'hFFFF;
    row.res.end_of_set = row.req.last_row;
    rows.insert(rows.size(), row);
    row.req = class_request(1, 16'sh8000);
    row.res.score_class = 7'd1;
    row.res.class_score = 16'd0;
    row.res.end_of_set = row.req.last_row;
    rows.insert(rows.size(), row);
    row.typed = 1'b0;
    row.req = class_request(80, 16'sh0100);
    rows.insert(rows.size(), row);
    row.req = class_request(127, 16'shFF00);
    rows.insert(rows.size(), row);
    row.req = class_request(40, 16'sh0001);
    rows.insert(rows.size(), row);
    row.req = class_request(41, 16'shFFFF);
    rows.insert(rows.size(), row);
    row.req = class_request(42, 16'sh0BF8);
    rows.insert(rows.size(), row);
    row.req = class_request(43, 16'shF408);
    rows.insert(rows.size(), row);
    row.req = class_request(44, 16'sh0C00);
    rows.insert(rows.size(), row);
    row.req = class_request(45, 16'shF3F0);
    rows.insert(rows.size(), row);
    row.req = class_request(46, 16'sh5A5A);
    rows.insert(rows.size(), row);
    row.req = class_request(47, 16'shA5A5);
    rows.insert(rows.size(), row);
    foreach (rows[i]) push_request(rows[i].req, rows[i].typed, rows[i].res);

    push_anchor(1'b1);
    while (items_sent < ItemGoal) begin
      if (items_sent > ItemGoal / 3 && tx_idle_pct == 6) begin
        tx_idle_pct = 72;
        rx_idle_pct = 6;
      end else if (items_sent > 2 * ItemGoal / 3 && tx_idle_pct == 72) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req = 1'b1;
      end
      push_anchor(1'b0);
    end
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // result side: check each taken result, then choose the next stall
  always @(posedge clk_i) begin
    dfl_box_pkg::out_res_t exp_res;
    if (out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, out_data_o);
        errors++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_data_o !== exp_res) begin
          $display("%0t: mismatch, expected %p, actual %p", $time, exp_res, out_data_o);
          errors++;
        end
      end
    end
    if (hold_req) begin
      hold_req <= 1'b0;
      hold_cnt <= HoldCycles;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
    out_stall_i <= hold_req || hold_cnt > 1 || ($urandom_range(99) < rx_idle_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || !rst_ni) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

endmodule
